@@ hdl/swsc_pkg.sv @@
// Package with shared types, constants and character helpers for the classifier.
package swsc_pkg;

  localparam int DEPTH_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_WORD = 2'd1,
    PH_CTE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CM_NONE  = 2'd0,
    CM_LINE  = 2'd1,
    CM_BLOCK = 2'd2,
    CM_STAR  = 2'd3
  } cmt_t;

  // Word carried from the front part to the result queue.
  typedef struct packed {
    logic is_write;
  } res_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a) || c == 8'h5f;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

@@ hdl/swsc_front.sv @@
// Front part: scans text bytes and produces one verdict word per statement.
module swsc_front import swsc_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] text_byte,
  input  logic       last_byte,
  output logic       res_vld,
  output res_t       res
);

  logic [7:0][7:0]       hist_r, hist_nxt;
  logic [7:0]            flag_r, flag_nxt;
  phase_t                phase_r, phase_nxt;
  cmt_t                  cmt_r, cmt_nxt;
  logic [7:0]            held_r, held_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic                  dec_r, dec_nxt;
  logic                  verd_r, verd_nxt;

  localparam logic [DEPTH_BITS-1:0] DMAX = {DEPTH_BITS{1'b1}};

  // Fourteen write keywords against a first word held in arrival order.
  function automatic logic word_match(input logic [7:0][7:0] h, input logic [3:0] n,
                                      input logic [7:0] tail);
    logic [8:0][7:0] u;
    logic            m;
    for (int i = 0; i < 9; i++) begin
      u[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        u[i] = to_upper(h[i]);
      end
    end
    u[n] = to_upper(tail);
    m = 1'b0;
    if (u[5:0] == {"T","R","E","S","N","I"} && !is_word(u[6])) m = 1'b1;
    if (u[5:0] == {"E","T","A","D","P","U"} && !is_word(u[6])) m = 1'b1;
    if (u[5:0] == {"E","T","E","L","E","D"} && !is_word(u[6])) m = 1'b1;
    if (u[4:0] == {"E","G","R","E","M"} && !is_word(u[5])) m = 1'b1;
    if (u[5:0] == {"E","T","A","E","R","C"} && !is_word(u[6])) m = 1'b1;
    if (u[3:0] == {"P","O","R","D"} && !is_word(u[4])) m = 1'b1;
    if (u[4:0] == {"R","E","T","L","A"} && !is_word(u[5])) m = 1'b1;
    if (u[7:0] == {"E","T","A","C","N","U","R","T"} && !is_word(u[8])) m = 1'b1;
    if (u[4:0] == {"T","N","A","R","G"} && !is_word(u[5])) m = 1'b1;
    if (u[5:0] == {"E","K","O","V","E","R"} && !is_word(u[6])) m = 1'b1;
    if (u[6:0] == {"T","N","E","M","M","O","C"} && !is_word(u[7])) m = 1'b1;
    if (u[3:0] == {"L","L","A","C"} && !is_word(u[4])) m = 1'b1;
    if (u[6:0] == {"H","S","E","R","F","E","R"} && !is_word(u[7])) m = 1'b1;
    if (u[6:0] == {"E","Z","Y","L","A","N","A"} && !is_word(u[7])) m = 1'b1;
    return m;
  endfunction

  // WITH-scan hit: bit 1 hit, bit 0 write verdict. History is newest first.
  function automatic logic [1:0] cte_hit(input logic [7:0][7:0] h, input logic [7:0] f,
                                         input logic [7:0] b);
    logic [7:0][7:0] u;
    logic [1:0]      r;
    for (int i = 0; i < 8; i++) begin
      u[i] = to_upper(h[i]);
    end
    r = 2'b00;
    if (!is_word(b)) begin
      if (f[5] && u[5:0] == {"I","N","S","E","R","T"}) r = 2'b11;
      else if (f[5] && u[5:0] == {"U","P","D","A","T","E"}) r = 2'b11;
      else if (f[5] && u[5:0] == {"D","E","L","E","T","E"}) r = 2'b11;
      else if (f[4] && u[4:0] == {"M","E","R","G","E"}) r = 2'b11;
      else if (f[5] && u[5:0] == {"S","E","L","E","C","T"}) r = 2'b10;
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic       cm;
    logic       plain;
    logic       fl;
    logic [1:0] hit;
    logic       to_cte;
    b         = text_byte;
    hist_nxt  = hist_r;
    flag_nxt  = flag_r;
    phase_nxt = phase_r;
    cmt_nxt   = cmt_r;
    held_nxt  = held_r;
    cnt_nxt   = cnt_r;
    depth_nxt = depth_r;
    dec_nxt   = dec_r;
    verd_nxt  = verd_r;
    cm        = 1'b0;
    plain     = 1'b1;
    fl        = 1'b0;
    hit       = 2'b00;
    to_cte    = 1'b0;

    if (byte_vld && !dec_r) begin
      if (b == 8'h00) begin
        dec_nxt = 1'b1;
        case (phase_r)
          PH_WORD: verd_nxt = word_match(hist_r, cnt_r, 8'h00);
          PH_CTE: begin
            hit      = cte_hit(hist_r, flag_r, 8'h00);
            verd_nxt = hit[1] & hit[0];
          end
          default: verd_nxt = 1'b0;
        endcase
      end else begin
        if (phase_r == PH_WORD && cnt_r == 4'd4 &&
            to_upper(hist_r[0]) == "W" && to_upper(hist_r[1]) == "I" &&
            to_upper(hist_r[2]) == "T" && to_upper(hist_r[3]) == "H" && !is_word(b)) begin
          to_cte = 1'b1;
        end
        if (phase_r == PH_CTE || to_cte) begin
          logic [7:0][7:0] hh;
          logic [7:0]      ff;
          logic [DEPTH_BITS-1:0] dd;
          cmt_t            cc;
          logic [7:0]      ho;
          hh = to_cte ? '0 : hist_r;
          ff = to_cte ? '0 : flag_r;
          dd = to_cte ? '0 : depth_r;
          cc = to_cte ? CM_NONE : cmt_r;
          ho = to_cte ? 8'h00 : held_r;
          phase_nxt = PH_CTE;
          depth_nxt = dd;
          cmt_nxt   = cc;
          held_nxt  = ho;
          hit = cte_hit(hh, ff, b);
          if (hit[1]) begin
            dec_nxt  = 1'b1;
            verd_nxt = hit[0];
          end else begin
            case (cc)
              CM_LINE: begin
                cm = 1'b1;
                if (b == 8'h0a) cmt_nxt = CM_NONE;
              end
              CM_BLOCK: begin
                cm = 1'b1;
                if (b == 8'h2a) cmt_nxt = CM_STAR;
              end
              CM_STAR: begin
                cm = 1'b1;
                if (b == 8'h2f) cmt_nxt = CM_NONE;
                else if (b != 8'h2a) cmt_nxt = CM_BLOCK;
              end
              default: cm = 1'b0;
            endcase
            if (!cm) begin
              if (ho != 8'h00) begin
                held_nxt = 8'h00;
                if (ho == 8'h2d && b == 8'h2d) begin
                  cmt_nxt = CM_LINE;
                  plain   = 1'b0;
                end else if (ho == 8'h2f && b == 8'h2a) begin
                  cmt_nxt = CM_BLOCK;
                  plain   = 1'b0;
                end
              end
              if (plain) begin
                if (b == 8'h28) begin
                  if (dd != DMAX) depth_nxt = dd + 1'b1;
                end else if (b == 8'h29) begin
                  if (dd != '0) depth_nxt = dd - 1'b1;
                end else if (dd == '0) begin
                  if (b == 8'h2d || b == 8'h2f) held_nxt = b;
                  else if (!is_blank(b)) fl = 1'b1;
                end
              end
            end
            hist_nxt = {hh[6:0], b};
            flag_nxt = {ff[6:0], fl};
          end
        end else if (phase_r == PH_WORD) begin
          if (cnt_r < 4'd8) begin
            hist_nxt[cnt_r[2:0]] = b;
            cnt_nxt              = cnt_r + 4'd1;
          end else begin
            dec_nxt  = 1'b1;
            verd_nxt = word_match(hist_r, cnt_r, b);
          end
        end else begin
          case (cmt_r)
            CM_LINE: begin
              cm = 1'b1;
              if (b == 8'h0a) cmt_nxt = CM_NONE;
            end
            CM_BLOCK: begin
              cm = 1'b1;
              if (b == 8'h2a) cmt_nxt = CM_STAR;
            end
            CM_STAR: begin
              cm = 1'b1;
              if (b == 8'h2f) cmt_nxt = CM_NONE;
              else if (b != 8'h2a) cmt_nxt = CM_BLOCK;
            end
            default: cm = 1'b0;
          endcase
          if (!cm) begin
            if (held_r != 8'h00) begin
              held_nxt = 8'h00;
              if (held_r == 8'h2d && b == 8'h2d) cmt_nxt = CM_LINE;
              else if (held_r == 8'h2f && b == 8'h2a) cmt_nxt = CM_BLOCK;
              else begin
                dec_nxt  = 1'b1;
                verd_nxt = 1'b0;
              end
            end else if (is_blank(b)) begin
              held_nxt = 8'h00;
            end else if (b == 8'h2d || b == 8'h2f) begin
              held_nxt = b;
            end else begin
              hist_nxt[0] = b;
              cnt_nxt     = 4'd1;
              phase_nxt   = PH_WORD;
            end
          end
        end
      end
    end
  end

  // Verdict at the last byte, taking end of text into account.
  always_comb begin
    logic [1:0] h2;
    res.is_write = verd_nxt;
    h2 = cte_hit(hist_nxt, flag_nxt, 8'h00);
    if (!dec_nxt) begin
      case (phase_nxt)
        PH_WORD: res.is_write = word_match(hist_nxt, cnt_nxt, 8'h00);
        PH_CTE:  res.is_write = h2[1] & h2[0];
        default: res.is_write = 1'b0;
      endcase
    end
    res_vld = byte_vld && last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_vld && last_byte)) begin
      hist_r  <= '0;
      flag_r  <= '0;
      phase_r <= PH_LEAD;
      cmt_r   <= CM_NONE;
      held_r  <= 8'h00;
      cnt_r   <= 4'd0;
      depth_r <= '0;
      dec_r   <= 1'b0;
      verd_r  <= 1'b0;
    end else begin
      hist_r  <= hist_nxt;
      flag_r  <= flag_nxt;
      phase_r <= phase_nxt;
      cmt_r   <= cmt_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
      depth_r <= depth_nxt;
      dec_r   <= dec_nxt;
      verd_r  <= verd_nxt;
    end
  end

endmodule

@@ hdl/swsc_queue.sv @@
// Result queue between the scanner and the output side.
module swsc_queue import swsc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic empty,
  output res_t rd_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  res_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = cnt_r == (AW+1)'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

@@ hdl/sql_write_statement_classifier.sv @@
// Top level of the SQL write-statement classifier.
// Each text byte is scanned in the cycle it is pushed, so one byte is taken per clock;
// the verdict word for a statement enters a two-word result queue in the cycle its last
// byte is pushed and can be popped on the next cycle. full is high whenever that queue
// holds two unread verdicts, and then no byte is taken, even one that ends no statement.
module sql_write_statement_classifier import swsc_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_text_byte,
  input  logic       in_last_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_is_write
);

  logic q_full;
  logic acc;
  logic res_vld;
  res_t res;
  res_t q_data;

  // Only a statement-ending byte needs room in the queue; full is held conservatively.
  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  swsc_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (acc),
    .text_byte (in_text_byte),
    .last_byte (in_last_byte),
    .res_vld   (res_vld),
    .res       (res)
  );

  swsc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_vld),
    .wr_data (res),
    .full    (q_full),
    .rd_en   (out_pop && !out_empty),
    .empty   (out_empty),
    .rd_data (q_data)
  );

  assign out_is_write = q_data.is_write;

endmodule
